[rtl/lcdseq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, codes and constants of the character LCD 4-bit write sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

   localparam int unsigned HOLD_W   = 16;
   localparam int unsigned NIB_W    = 4;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [HOLD_W-1:0] NIBBLE_HOLD_RST  = 16'd500;
   localparam logic [HOLD_W-1:0] POWERUP_WAIT_RST = 16'd40000;
   localparam logic [HOLD_W-1:0] WAKE_GAP_RST     = 16'd200;
   localparam logic [HOLD_W-1:0] FNSET_GAP_RST    = 16'd40;

   localparam logic [NIB_W-1:0] WAKE_NIBBLE  = 4'h3;
   localparam logic [NIB_W-1:0] MODE4_NIBBLE = 4'h2;

   // init: 3 wake nibbles, 1 mode nibble, then 5 command bytes (10 nibbles)
   localparam logic [3:0] NIDX_MODE     = 4'd3;
   localparam logic [3:0] NIDX_CMD_BASE = 4'd4;
   localparam logic [3:0] NIDX_INIT_END = 4'd13;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INIT = 2'd0,
      ACT_CMD  = 2'd1,
      ACT_CHAR = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NIBBLE_HOLD  = 2'd0,
      CSR_POWERUP_WAIT = 2'd1,
      CSR_WAKE_GAP     = 2'd2,
      CSR_FNSET_GAP    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAD,
      ST_NIB,
      ST_GAP,
      ST_TAIL
   } state_type;

   typedef enum logic [2:0] {
      NSRC_HELD,
      NSRC_WAKE,
      NSRC_MODE,
      NSRC_BYTE_HI,
      NSRC_BYTE_LO,
      NSRC_CMD_HI,
      NSRC_CMD_LO
   } nib_src_type;

   typedef enum logic [2:0] {
      HSRC_NIBBLE,
      HSRC_POWERUP,
      HSRC_WAKE,
      HSRC_FNSET,
      HSRC_ZERO
   } hold_src_type;

   typedef struct packed {
      logic         load_byte;
      logic         emit;
      nib_src_type  nib_src;
      logic [2:0]   cmd_idx;
      logic         rs;
      logic         en;
      hold_src_type hold_src;
      logic         last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_stat_type;

   function automatic logic [BYTE_W-1:0] init_cmd(input logic [2:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         3'd0:    b = 8'h28;
         3'd1:    b = 8'h10;
         3'd2:    b = 8'h0F;
         3'd3:    b = 8'h06;
         3'd4:    b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[rtl/lcdseq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Sequencer state machine: walks the pin-state run of one item and issues
// one emit command per state to the datapath.
// ----------------------------------------------------------------------------
module lcdseq_ctrl
   import lcdseq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACTION_W-1:0] req_action,
   input  dp_stat_type         stat,
   output dp_cmd_type          cmd
);

   state_type  state_ff, state_in;
   action_type mode_ff, mode_in;
   logic [1:0] phase_ff, phase_in;
   logic [3:0] nidx_ff, nidx_in;

   logic       accept;
   logic       is_init;
   logic       is_char;
   logic       last_nib;
   logic [3:0] nidx_m4;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_init   = (mode_ff == ACT_INIT);
   assign is_char   = (mode_ff == ACT_CHAR);
   assign last_nib  = is_init ? (nidx_ff == NIDX_INIT_END) : (nidx_ff == 4'd1);
   assign nidx_m4   = nidx_ff - NIDX_CMD_BASE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= ACT_NONE;
         phase_ff <= 2'd0;
         nidx_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         nidx_ff  <= nidx_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      phase_in = phase_ff;
      nidx_in  = nidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = action_type'(req_action);
               phase_in = 2'd0;
               nidx_in  = 4'd0;
               unique case (action_type'(req_action))
                  ACT_INIT, ACT_CHAR: state_in = ST_LEAD;
                  ACT_CMD:            state_in = ST_NIB;
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_LEAD: begin
            if (stat.out_free) state_in = ST_NIB;
         end
         ST_NIB: begin
            if (stat.out_free) begin
               if (phase_ff != 2'd2) begin
                  phase_in = phase_ff + 2'd1;
               end else begin
                  phase_in = 2'd0;
                  if (is_init && (nidx_ff < NIDX_CMD_BASE)) begin
                     state_in = ST_GAP;
                  end else if (last_nib) begin
                     state_in = is_char ? ST_TAIL : ST_IDLE;
                  end else begin
                     nidx_in = nidx_ff + 4'd1;
                  end
               end
            end
         end
         ST_GAP: begin
            if (stat.out_free) begin
               state_in = ST_NIB;
               nidx_in  = nidx_ff + 4'd1;
            end
         end
         ST_TAIL: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.nib_src   = NSRC_HELD;
      cmd.hold_src  = HSRC_NIBBLE;
      cmd.load_byte = accept;
      cmd.cmd_idx   = nidx_m4[3:1];
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_LEAD: begin
            cmd.emit     = stat.out_free;
            cmd.nib_src  = NSRC_HELD;
            cmd.rs       = is_char;
            cmd.hold_src = is_init ? HSRC_POWERUP : HSRC_NIBBLE;
         end
         ST_NIB: begin
            cmd.emit     = stat.out_free;
            cmd.rs       = is_char;
            cmd.en       = (phase_ff == 2'd1);
            cmd.hold_src = HSRC_NIBBLE;
            cmd.last     = (phase_ff == 2'd2) && last_nib && !is_char;
            if (is_init) begin
               if (nidx_ff < NIDX_MODE)        cmd.nib_src = NSRC_WAKE;
               else if (nidx_ff == NIDX_MODE)  cmd.nib_src = NSRC_MODE;
               else if (!nidx_m4[0])           cmd.nib_src = NSRC_CMD_HI;
               else                            cmd.nib_src = NSRC_CMD_LO;
            end else begin
               cmd.nib_src = (nidx_ff == 4'd0) ? NSRC_BYTE_HI : NSRC_BYTE_LO;
            end
         end
         ST_GAP: begin
            cmd.emit     = stat.out_free;
            cmd.nib_src  = (nidx_ff == NIDX_MODE) ? NSRC_MODE : NSRC_WAKE;
            cmd.hold_src = (nidx_ff == NIDX_MODE) ? HSRC_FNSET : HSRC_WAKE;
         end
         ST_TAIL: begin
            cmd.emit     = stat.out_free;
            cmd.nib_src  = NSRC_BYTE_LO;
            cmd.hold_src = HSRC_ZERO;
            cmd.last     = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/lcdseq_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_dp
// Datapath: timing registers, byte latch, held data level and the pin-state
// output register.
// ----------------------------------------------------------------------------
module lcdseq_dp
   import lcdseq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic [BYTE_W-1:0]    req_byte_value,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [HOLD_W-1:0]    csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [NIB_W-1:0]     rsp_data_nibble,
   output logic                 rsp_reg_select,
   output logic                 rsp_enable,
   output logic [HOLD_W-1:0]    rsp_hold_us,
   output logic                 rsp_last
);

   logic [HOLD_W-1:0] nibble_hold_ff, powerup_wait_ff, wake_gap_ff, fnset_gap_ff;
   logic [NIB_W-1:0]  held_nibble_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              valid_ff;
   logic [NIB_W-1:0]  nib_ff;
   logic              rs_ff, en_ff, last_ff;
   logic [HOLD_W-1:0] hold_ff;

   logic [NIB_W-1:0]  nib_in;
   logic [HOLD_W-1:0] hold_in;
   logic [BYTE_W-1:0] cmd_byte;

   assign csr_ready     = 1'b1;
   assign stat.out_free = !valid_ff || rsp_ready;
   assign cmd_byte      = init_cmd(cmd.cmd_idx);

   always_comb begin
      case (cmd.nib_src)
         NSRC_HELD:    nib_in = held_nibble_ff;
         NSRC_WAKE:    nib_in = WAKE_NIBBLE;
         NSRC_MODE:    nib_in = MODE4_NIBBLE;
         NSRC_BYTE_HI: nib_in = byte_ff[7:4];
         NSRC_BYTE_LO: nib_in = byte_ff[3:0];
         NSRC_CMD_HI:  nib_in = cmd_byte[7:4];
         NSRC_CMD_LO:  nib_in = cmd_byte[3:0];
         default:      nib_in = held_nibble_ff;
      endcase
   end

   always_comb begin
      case (cmd.hold_src)
         HSRC_NIBBLE:  hold_in = nibble_hold_ff;
         HSRC_POWERUP: hold_in = powerup_wait_ff;
         HSRC_WAKE:    hold_in = wake_gap_ff;
         HSRC_FNSET:   hold_in = fnset_gap_ff;
         default:      hold_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nibble_hold_ff  <= NIBBLE_HOLD_RST;
         powerup_wait_ff <= POWERUP_WAIT_RST;
         wake_gap_ff     <= WAKE_GAP_RST;
         fnset_gap_ff    <= FNSET_GAP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_NIBBLE_HOLD:  nibble_hold_ff  <= csr_data;
            CSR_POWERUP_WAIT: powerup_wait_ff <= csr_data;
            CSR_WAKE_GAP:     wake_gap_ff     <= csr_data;
            CSR_FNSET_GAP:    fnset_gap_ff    <= csr_data;
            default:          nibble_hold_ff  <= nibble_hold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_nibble_ff <= '0;
         valid_ff       <= 1'b0;
      end else begin
         if (cmd.emit) begin
            held_nibble_ff <= nib_in;
            valid_ff       <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) byte_ff <= req_byte_value;
      if (cmd.emit) begin
         nib_ff  <= nib_in;
         rs_ff   <= cmd.rs;
         en_ff   <= cmd.en;
         hold_ff <= hold_in;
         last_ff <= cmd.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_data_nibble = nib_ff;
   assign rsp_reg_select  = rs_ff;
   assign rsp_enable      = en_ff;
   assign rsp_hold_us     = hold_ff;
   assign rsp_last        = last_ff;

endmodule

[rtl/char_lcd_nibble_write_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Character LCD 4-bit bus sequencer: turns init / command / character items
// into runs of pin states (data nibble, RS, enable, hold time).
// ----------------------------------------------------------------------------
// An accepted item is registered in the state machine, and its first pin state
// is then registered in the output register.
// Throughput: one pin state per cycle from the sequencer state machine while
//   rsp_ready is high.
// One item at a time; the next is taken once the last state is registered.
// Reset: timing registers return to 500/40000/200/40 us, held data level 0.
module char_lcd_nibble_write_sequencer
   import lcdseq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [BYTE_W-1:0]    req_byte_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [NIB_W-1:0]     rsp_data_nibble,
   output logic                 rsp_reg_select,
   output logic                 rsp_enable,
   output logic [HOLD_W-1:0]    rsp_hold_us,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [HOLD_W-1:0]    csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   lcdseq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   lcdseq_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_byte_value  (req_byte_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_nibble (rsp_data_nibble),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_enable      (rsp_enable),
      .rsp_hold_us     (rsp_hold_us),
      .rsp_last        (rsp_last)
   );

endmodule

[rtl/lcdseq_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_chk
// Port-level checks of the LCD sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdseq_chk
   import lcdseq_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [ACTION_W-1:0]  req_action,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [NIB_W-1:0]     rsp_data_nibble,
   input logic                 rsp_reg_select,
   input logic                 rsp_enable,
   input logic [HOLD_W-1:0]    rsp_hold_us,
   input logic                 rsp_last
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_nibble)
         && $stable(rsp_enable) && $stable(rsp_hold_us) && $stable(rsp_last))
      else $error("stalled rsp item changed");

   // a command run is in progress right after it is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_CMD) |=> !req_ready)
      else $error("req_ready high during command run");

   // final state of a run leaves RS and enable low
   a_last_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !rsp_reg_select && !rsp_enable)
      else $error("last state with RS or enable high");

   // enable high is always followed by enable low
   a_en_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_enable ##1 rsp_valid |-> !rsp_enable)
      else $error("enable high twice in a row");

endmodule

bind char_lcd_nibble_write_sequencer lcdseq_chk u_chk (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - char_lcd_nibble_write_sequencer testbench
// Sends init, command, character and unused-code items under several timing
// register settings, predicts every LCD pin state in a scoreboard and checks
// each state that comes out, in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
   import lcdseq_pkg::*;

   typedef struct packed {
      logic [NIB_W-1:0]  nib;
      logic              rs;
      logic              en;
      logic [HOLD_W-1:0] hold;
      logic              last;
   } pin_state_type;

   // Predicts the pin-state runs of each accepted item and checks them in order.
   class lcd_pin_scoreboard;
      logic [HOLD_W-1:0] nibble_hold;
      logic [HOLD_W-1:0] powerup_wait;
      logic [HOLD_W-1:0] wake_gap;
      logic [HOLD_W-1:0] fnset_gap;
      logic [NIB_W-1:0]  data_level;
      logic [BYTE_W-1:0] boot_cmds [5];
      pin_state_type     pending_pins [$];
      int unsigned       mismatches;
      int unsigned       checked;

      function new();
         nibble_hold  = NIBBLE_HOLD_RST;
         powerup_wait = POWERUP_WAIT_RST;
         wake_gap     = WAKE_GAP_RST;
         fnset_gap    = FNSET_GAP_RST;
         data_level   = '0;
         boot_cmds    = '{8'h28, 8'h10, 8'h0F, 8'h06, 8'h01};
         mismatches   = 0;
         checked      = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [HOLD_W-1:0] value);
         case (idx)
            CSR_NIBBLE_HOLD:  nibble_hold  = value;
            CSR_POWERUP_WAIT: powerup_wait = value;
            CSR_WAKE_GAP:     wake_gap     = value;
            CSR_FNSET_GAP:    fnset_gap    = value;
            default: ;
         endcase
      endfunction

      function void push_pin(logic [NIB_W-1:0] nib, logic rs, logic en,
                             logic [HOLD_W-1:0] hold);
         pending_pins.push_back('{nib: nib, rs: rs, en: en, hold: hold, last: 1'b0});
         data_level = nib;
      endfunction

      // setup, enable high, enable low
      function void push_nibble(logic [NIB_W-1:0] nib, logic rs);
         push_pin(nib, rs, 1'b0, nibble_hold);
         push_pin(nib, rs, 1'b1, nibble_hold);
         push_pin(nib, rs, 1'b0, nibble_hold);
      endfunction

      function void push_byte(logic [BYTE_W-1:0] b, logic rs);
         push_nibble(b[7:4], rs);
         push_nibble(b[3:0], rs);
      endfunction

      function void note_item(action_type act, logic [BYTE_W-1:0] b);
         int unsigned   base;
         pin_state_type tail;
         base = pending_pins.size();
         case (act)
            ACT_INIT: begin
               push_pin(data_level, 1'b0, 1'b0, powerup_wait);
               for (int i = 0; i < 3; i++) begin
                  push_nibble(WAKE_NIBBLE, 1'b0);
                  push_pin(WAKE_NIBBLE, 1'b0, 1'b0, wake_gap);
               end
               push_nibble(MODE4_NIBBLE, 1'b0);
               push_pin(MODE4_NIBBLE, 1'b0, 1'b0, fnset_gap);
               for (int i = 0; i < 5; i++) push_byte(boot_cmds[i], 1'b0);
            end
            ACT_CMD: push_byte(b, 1'b0);
            ACT_CHAR: begin
               // RS rises on the held data level, then drops at the end
               push_pin(data_level, 1'b1, 1'b0, nibble_hold);
               push_byte(b, 1'b1);
               push_pin(b[3:0], 1'b0, 1'b0, '0);
            end
            default: ;
         endcase
         if (pending_pins.size() > base) begin
            tail = pending_pins.pop_back();
            tail.last = 1'b1;
            pending_pins.push_back(tail);
         end
      endfunction

      function void check_pin(pin_state_type got);
         pin_state_type want;
         if (pending_pins.size() == 0) begin
            $error("unexpected pin state: nibble %0h rs %0b en %0b hold %0d last %0b",
                   got.nib, got.rs, got.en, got.hold, got.last);
            mismatches++;
            return;
         end
         want = pending_pins.pop_front();
         checked++;
         if (got.nib !== want.nib) begin
            $error("data_nibble: expected %0h, got %0h", want.nib, got.nib);
            mismatches++;
         end
         if (got.rs !== want.rs) begin
            $error("reg_select: expected %0b, got %0b", want.rs, got.rs);
            mismatches++;
         end
         if (got.en !== want.en) begin
            $error("enable: expected %0b, got %0b", want.en, got.en);
            mismatches++;
         end
         if (got.hold !== want.hold) begin
            $error("hold_us: expected %0d, got %0d", want.hold, got.hold);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [ACTION_W-1:0]  req_action;
   logic [BYTE_W-1:0]    req_byte_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [NIB_W-1:0]     rsp_data_nibble;
   logic                 rsp_reg_select;
   logic                 rsp_enable;
   logic [HOLD_W-1:0]    rsp_hold_us;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [HOLD_W-1:0]    csr_data;

   lcd_pin_scoreboard board;
   bit                quiet;
   int unsigned       n_init, n_cmd, n_char, n_none, n_settings;

   char_lcd_nibble_write_sequencer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_byte_value  (req_byte_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_nibble (rsp_data_nibble),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_enable      (rsp_enable),
      .rsp_hold_us     (rsp_hold_us),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // receiver stalls
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ready <= quiet || ($urandom_range(0, 99) >= 14);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_pin('{nib: rsp_data_nibble, rs: rsp_reg_select, en: rsp_enable,
                           hold: rsp_hold_us, last: rsp_last});
   end

   // Leaves req_valid high after acceptance; the caller lowers it.
   task automatic send_item(action_type act, logic [BYTE_W-1:0] b);
      if (!quiet && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_byte_value <= b;
      do @(posedge clock); while (!req_ready);
      board.note_item(act, b);
      case (act)
         ACT_INIT: n_init++;
         ACT_CMD:  n_cmd++;
         ACT_CHAR: n_char++;
         default:  n_none++;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_pins.size() != 0) @(posedge clock);
      // unused-code items leave nothing to wait on
      repeat (4) @(posedge clock);
   endtask

   task automatic load_timing(logic [HOLD_W-1:0] hold, logic [HOLD_W-1:0] pwr,
                              logic [HOLD_W-1:0] wake, logic [HOLD_W-1:0] fnset);
      logic [HOLD_W-1:0] vals [4];
      vals = '{hold, pwr, wake, fnset};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         board.set_reg(csr_index_type'(i), vals[i]);
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic random_items(int unsigned count);
      int unsigned roll;
      action_type  act;
      send_item(ACT_INIT, BYTE_W'($urandom_range(0, 255)));
      for (int unsigned k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 6)       act = ACT_INIT;
         else if (roll < 46) act = ACT_CMD;
         else if (roll < 92) act = ACT_CHAR;
         else                act = ACT_NONE;
         send_item(act, BYTE_W'($urandom_range(0, 255)));
      end
      drain();
   endtask

   initial begin
      board = new();
      quiet = 1'b0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_action     <= ACT_NONE;
      req_byte_value <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_NIBBLE_HOLD;
      csr_data       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset timing, byte extremes, held data level, unused code
      send_item(ACT_CHAR, 8'hA5);
      send_item(ACT_INIT, 8'hFF);
      send_item(ACT_CMD,  8'h00);
      send_item(ACT_CMD,  8'hFF);
      send_item(ACT_CHAR, 8'hFF);
      send_item(ACT_CHAR, 8'h00);
      send_item(ACT_NONE, 8'hFF);
      send_item(ACT_CHAR, 8'h5A);
      send_item(ACT_NONE, 8'h00);
      send_item(ACT_INIT, 8'h00);
      send_item(ACT_CMD,  8'h12);
      send_item(ACT_CHAR, 8'hC3);
      send_item(ACT_INIT, 8'hA7);
      send_item(ACT_CMD,  8'h80);
      send_item(ACT_CHAR, 8'h7E);
      send_item(ACT_NONE, 8'h81);
      send_item(ACT_CHAR, 8'h01);
      send_item(ACT_CMD,  8'hF0);
      drain();

      load_timing(16'd0, 16'd0, 16'd0, 16'd0);
      random_items(30);

      // no idling on either side for this stretch
      quiet = 1'b1;
      load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_items(30);
      quiet = 1'b0;

      load_timing(HOLD_W'($urandom), HOLD_W'($urandom), HOLD_W'($urandom),
                  HOLD_W'($urandom));
      random_items(33);

      load_timing(16'd1, 16'hFFFF, 16'd0, 16'd12345);
      random_items(33);

      load_timing(NIBBLE_HOLD_RST, POWERUP_WAIT_RST, WAKE_GAP_RST, FNSET_GAP_RST);
      random_items(33);

      repeat (20) @(posedge clock);
      if (board.pending_pins.size() != 0) begin
         $error("%0d pin states never arrived", board.pending_pins.size());
         board.mismatches++;
      end

      $display("Items: %0d init, %0d command, %0d character, %0d unused code",
               n_init, n_cmd, n_char, n_none);
      $display("%0d pin states checked over %0d timing register settings",
               board.checked, n_settings + 1);
      if (board.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
